>>> rtl/core/tafg_pkg.sv
// Shared types, constants and table functions of the tile fetch generator.
package tafg_pkg;

    // Tile geometry. The tile edge is a power of two so that map positions and
    // sub-tile offsets come from shifts and masks of the scroll registers.
    localparam int TILE_PIXELS   = 32;
    localparam int TILE_SHIFT    = $clog2(TILE_PIXELS);
    localparam int HALF_SHIFT    = TILE_SHIFT - 1;
    localparam int HALF_PIXELS   = TILE_PIXELS / 2;
    localparam int SHEET_STRIDE  = 3 * TILE_PIXELS;

    localparam int FRAME_BITS_DEF = 16;

    // Tile id ranges.
    localparam int TILESET_BASE  = 384;
    localparam int IDS_PER_SHEET = 48;
    localparam int SHEET_COUNT   = TILESET_BASE / IDS_PER_SHEET - 1;

    // Animation.
    localparam int TICK_BITS     = 3;
    localparam int MAX_FRAMES    = 15;

    // Queue between front and back.
    localparam int QUEUE_DEPTH   = 2;

    // Field widths.
    localparam int COL_W    = 6;
    localparam int ROW_W    = 6;
    localparam int LAYER_W  = 3;
    localparam int ID_W     = 13;
    localparam int PRIO_W   = 3;
    localparam int LEVEL_W  = 12;
    localparam int FRAMES_W = 4;
    localparam int SHEET_W  = 3;
    localparam int SRC_W    = 15;
    localparam int DST_W    = 12;
    localparam int SCROLL_W = 16;
    localparam int MAPDIM_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;
    localparam int ARR_W      = 6;
    localparam int QCODE_W    = 6;

    // Division of a quarter code (below 48) by 6 as a multiply and shift.
    localparam int DIV6_RECIP = 43;
    localparam int DIV6_SHIFT = 8;
    localparam int QUARTER_COLS = 6;

    typedef enum logic {
        OP_FETCH = 1'b0,
        OP_TICK  = 1'b1
    } t_opcode;

    typedef enum logic {
        KIND_TILE    = 1'b0,
        KIND_QUARTER = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCROLL_X   = 2'd0,
        CFG_SCROLL_Y   = 2'd1,
        CFG_MAP_WIDTH  = 2'd2,
        CFG_MAP_HEIGHT = 2'd3
    } t_cfg_index;

    // One classified tile as it waits for the back end. src holds the base
    // source position: the tileset cell, or the animation frame offset of
    // an autotile sheet.
    typedef struct packed {
        t_kind                     kind;
        logic [SHEET_W-1:0]        sheet;
        logic [ARR_W-1:0]          arr;
        logic [SRC_W-1:0]          src_x;
        logic [SRC_W-1:0]          src_y;
        logic signed [DST_W-1:0]   dst_x;
        logic signed [DST_W-1:0]   dst_y;
    } t_desc;

    // Quarter cells for each of the 48 autotile arrangements, in the order
    // top-left, top-right, bottom-left, bottom-right.
    localparam int unsigned QUARTER_MAP [IDS_PER_SHEET][4] = '{
        '{26, 27, 32, 33}, '{ 4, 27, 32, 33}, '{26,  5, 32, 33}, '{ 4,  5, 32, 33},
        '{26, 27, 32, 11}, '{ 4, 27, 32, 11}, '{26,  5, 32, 11}, '{ 4,  5, 32, 11},
        '{26, 27, 10, 33}, '{ 4, 27, 10, 33}, '{26,  5, 10, 33}, '{ 4,  5, 10, 33},
        '{26, 27, 10, 11}, '{ 4, 27, 10, 11}, '{26,  5, 10, 11}, '{ 4,  5, 10, 11},
        '{24, 25, 30, 31}, '{24,  5, 30, 31}, '{24, 25, 30, 11}, '{24,  5, 30, 11},
        '{14, 15, 20, 21}, '{14, 15, 20, 11}, '{14, 15, 10, 21}, '{14, 15, 10, 11},
        '{28, 29, 34, 35}, '{28, 29, 10, 35}, '{ 4, 29, 34, 35}, '{ 4, 29, 10, 35},
        '{38, 39, 44, 45}, '{ 4, 39, 44, 45}, '{38,  5, 44, 45}, '{ 4,  5, 44, 45},
        '{24, 29, 30, 35}, '{14, 15, 44, 45}, '{12, 13, 18, 19}, '{12, 13, 18, 11},
        '{16, 17, 22, 23}, '{16, 17, 10, 23}, '{40, 41, 46, 47}, '{ 4, 41, 46, 47},
        '{36, 37, 42, 43}, '{36,  5, 42, 43}, '{12, 17, 18, 23}, '{12, 13, 42, 43},
        '{36, 41, 42, 47}, '{16, 17, 46, 47}, '{12, 17, 42, 47}, '{ 0,  1,  6,  7}
    };

    function automatic logic [QCODE_W-1:0] quarter_code(input logic [ARR_W-1:0] arr,
                                                        input logic [1:0] idx);
        return QCODE_W'(QUARTER_MAP[arr][idx]);
    endfunction

    // Row of a quarter cell within the six-wide sheet layout.
    function automatic logic [2:0] quarter_row(input logic [QCODE_W-1:0] q);
        logic [11:0] prod;
        prod = 12'(q) * 12'(DIV6_RECIP);
        return 3'(prod >> DIV6_SHIFT);
    endfunction

    // Column of a quarter cell within the six-wide sheet layout.
    function automatic logic [2:0] quarter_col(input logic [QCODE_W-1:0] q);
        logic [QCODE_W-1:0] base;
        base = QCODE_W'(quarter_row(q)) * QCODE_W'(QUARTER_COLS);
        return 3'(q - base);
    endfunction

endpackage

>>> rtl/core/tafg_front.sv
// Front end: configuration, animation counters and tile classification.
module tafg_front
    import tafg_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_opcode               i_opcode,
    input  logic [IN_DATA_W-1:0]  i_data,
    input  logic                  i_cfg_valid,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_full,
    output logic                  o_push,
    output t_desc                 o_desc
);

    localparam logic [TICK_BITS-1:0] TICK_LAST = '1;

    logic [SCROLL_W-1:0]   r_scroll_x, r_scroll_y;
    logic [MAPDIM_W-1:0]   r_map_w, r_map_h;
    logic [TICK_BITS-1:0]  r_tick;
    logic [FRAME_BITS-1:0] r_anim;
    // r_res[f] holds the animation frame modulo f+1.
    logic [FRAMES_W-1:0]   r_res [MAX_FRAMES];

    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [LAYER_W-1:0]  layer;
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   prio;
    logic [LEVEL_W-1:0]  level;
    logic [FRAMES_W-1:0] frames;

    logic                accept;
    logic [16:0]         map_x, map_y;
    logic [12:0]         key_base, key;
    logic                on_map, key_hit;
    logic [FRAMES_W-1:0] frame;
    logic [ID_W-1:0]     tile_n;
    logic [2:0]          sheet_p1;
    logic [8:0]          arr_full;
    logic                is_tileset, is_auto, emit;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign col    = i_data[5:0];
    assign row    = i_data[11:6];
    assign layer  = i_data[14:12];
    assign id     = i_data[27:15];
    assign prio   = i_data[30:28];
    assign level  = i_data[42:31];
    assign frames = i_data[46:43];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x <= '0;
            r_scroll_y <= '0;
            r_map_w    <= '0;
            r_map_h    <= '0;
            r_tick     <= '0;
            r_anim     <= '0;
            for (int f = 0; f < MAX_FRAMES; f++) r_res[f] <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SCROLL_X:   r_scroll_x <= i_cfg_data;
                    CFG_SCROLL_Y:   r_scroll_y <= i_cfg_data;
                    CFG_MAP_WIDTH:  r_map_w    <= i_cfg_data[MAPDIM_W-1:0];
                    CFG_MAP_HEIGHT: r_map_h    <= i_cfg_data[MAPDIM_W-1:0];
                    default: ;
                endcase
            end
            if (accept && i_opcode == OP_TICK) begin
                r_tick <= r_tick + 1'b1;
                if (r_tick == TICK_LAST) begin
                    r_anim <= r_anim + 1'b1;
                    // The residues follow the counter, and restart with it when it wraps.
                    for (int f = 0; f < MAX_FRAMES; f++) begin
                        if (r_anim == '1 || r_res[f] == FRAMES_W'(f))
                            r_res[f] <= '0;
                        else
                            r_res[f] <= r_res[f] + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        map_x  = 17'(r_scroll_x >> TILE_SHIFT) + 17'(col);
        map_y  = 17'(r_scroll_y >> TILE_SHIFT) + 17'(row);
        on_map = (map_x < 17'(r_map_w)) && (map_y < 17'(r_map_h));

        key_base = 13'(prio) + 13'(row) + 13'(layer);
        if (prio == '0) begin
            key = '0;
        end else begin
            key = key_base << TILE_SHIFT;
            if (map_y == '0 && prio == PRIO_W'(1)) key = key + 13'(TILE_PIXELS);
        end
        key_hit = (key == 13'(level));

        frame = (frames != '0) ? r_res[frames - 1'b1] : '0;

        sheet_p1 = '0;
        for (int k = 1; k <= SHEET_COUNT; k++) begin
            if (id[8:0] >= 9'(k * IDS_PER_SHEET)) sheet_p1 = 3'(k);
        end
        arr_full = id[8:0] - 9'(sheet_p1) * 9'(IDS_PER_SHEET);

        tile_n     = id - ID_W'(TILESET_BASE);
        is_tileset = id >= ID_W'(TILESET_BASE);
        is_auto    = !is_tileset && id >= ID_W'(IDS_PER_SHEET) && frames != '0;
        emit       = on_map && key_hit && (is_tileset || is_auto);

        o_desc.dst_x = $signed(DST_W'(col) << TILE_SHIFT)
                     - $signed(DST_W'(r_scroll_x[TILE_SHIFT-1:0]));
        o_desc.dst_y = $signed(DST_W'(row) << TILE_SHIFT)
                     - $signed(DST_W'(r_scroll_y[TILE_SHIFT-1:0]));
        o_desc.arr   = arr_full[ARR_W-1:0];
        if (is_tileset) begin
            o_desc.kind  = KIND_TILE;
            o_desc.sheet = '0;
            o_desc.src_x = SRC_W'(tile_n[2:0]) << TILE_SHIFT;
            o_desc.src_y = SRC_W'(tile_n[ID_W-1:3]) << TILE_SHIFT;
        end else begin
            o_desc.kind  = KIND_QUARTER;
            o_desc.sheet = sheet_p1 - 1'b1;
            o_desc.src_x = SRC_W'(frame) * SRC_W'(SHEET_STRIDE);
            o_desc.src_y = '0;
        end
    end

    assign o_push = accept && i_opcode == OP_FETCH && emit;

endmodule

>>> rtl/core/tafg_queue.sv
// Short queue of classified tiles between the front and back ends.
module tafg_queue
    import tafg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output t_desc o_desc,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_desc            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_desc;
    end

endmodule

>>> rtl/core/tafg_back.sv
// Back end: expands a classified tile into rectangles in an output register.
module tafg_back
    import tafg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_desc                 i_desc,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data,
    output t_kind                 o_kind,
    output logic                  o_last
);

    logic [1:0]              r_quad;
    logic                    r_valid;
    t_kind                   r_kind;
    logic [SHEET_W-1:0]      r_sheet;
    logic [SRC_W-1:0]        r_src_x, r_src_y;
    logic signed [DST_W-1:0] r_dst_x, r_dst_y;
    logic                    r_last;

    logic                    load, last_rect;
    logic [QCODE_W-1:0]      q;
    logic [SRC_W-1:0]        n_src_x, n_src_y;
    logic signed [DST_W-1:0] n_dst_x, n_dst_y;

    assign load      = !i_empty && (!r_valid || i_ready);
    assign last_rect = i_desc.kind == KIND_TILE || r_quad == 2'd3;
    assign o_pop     = load && last_rect;

    always_comb begin
        q = quarter_code(i_desc.arr, r_quad);
        if (i_desc.kind == KIND_QUARTER) begin
            n_src_x = i_desc.src_x + (SRC_W'(quarter_col(q)) << HALF_SHIFT);
            n_src_y = i_desc.src_y + (SRC_W'(quarter_row(q)) << HALF_SHIFT);
            n_dst_x = i_desc.dst_x + (r_quad[0] ? DST_W'(HALF_PIXELS) : '0);
            n_dst_y = i_desc.dst_y + (r_quad[1] ? DST_W'(HALF_PIXELS) : '0);
        end else begin
            n_src_x = i_desc.src_x;
            n_src_y = i_desc.src_y;
            n_dst_x = i_desc.dst_x;
            n_dst_y = i_desc.dst_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_quad  <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_quad  <= last_rect ? 2'd0 : r_quad + 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= i_desc.kind;
            r_sheet <= i_desc.sheet;
            r_src_x <= n_src_x;
            r_src_y <= n_src_y;
            r_dst_x <= n_dst_x;
            r_dst_y <= n_dst_y;
            r_last  <= last_rect;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_last  = r_last;
    assign o_data  = {7'b0, r_dst_y, r_dst_x, r_src_y, r_src_x, r_sheet};

endmodule

>>> rtl/core/tilemap_autotile_fetch_generator.sv
// An accepted tile goes into the queue, then its first rectangle into the output register.
// Throughput: one item per cycle into the front end while the queue has room; a tileset tile
// gives one rectangle and an autotile four, driven one per cycle while the output is ready.
// The input stalls while the two-entry queue is full, so tiles then follow the output's pace.
// Tick items and tiles that give no rectangle never reach the queue.
// Reset (synchronous, active low) clears the registers, the animation counters and the queue.
module tilemap_autotile_fetch_generator
    import tafg_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input items.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // screen_col[5:0], screen_row[11:6], layer[14:12], tile_id[27:15],
    // tile_priority[30:28], draw_level[42:31], sheet_frames[46:43], zero[47]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // opcode[0]
    input  logic                  i_s_tuser,
    // Result items.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // sheet[2:0], src_x[17:3], src_y[32:18], dst_x[44:33], dst_y[56:45], zero[63:57]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // kind[0]
    output logic                  o_m_tuser,
    output logic                  o_m_tlast,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // The front end accepts items while the queue has room, steps the
    // animation counters on ticks and turns each tile item into either
    // nothing or one queue entry that carries its whole geometry:
    // destination corner, base source position (tileset cell or animation
    // frame offset), sheet and arrangement. The back end pops an entry and
    // walks its rectangles through the output register, so the two sides
    // stall independently. The animation frame is sampled when a tile is
    // classified, which keeps ticks and tiles in their arrival order even
    // while tiles still wait.

    t_desc q_in, q_out;
    logic  q_push, q_pop, q_full, q_empty;
    t_kind out_kind;

    // Configuration registers are plain flops, always writable.
    assign o_cfg_ready = 1'b1;

    tafg_front #(
        .FRAME_BITS(FRAME_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_opcode   (t_opcode'(i_s_tuser)),
        .i_data     (i_s_tdata),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(t_cfg_index'(i_cfg_index)),
        .i_cfg_data (i_cfg_data),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_desc     (q_in)
    );

    tafg_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_desc (q_in),
        .i_pop  (q_pop),
        .o_desc (q_out),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    tafg_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(q_empty),
        .i_desc (q_out),
        .o_pop  (q_pop),
        .o_valid(o_m_tvalid),
        .i_ready(i_m_tready),
        .o_data (o_m_tdata),
        .o_kind (out_kind),
        .o_last (o_m_tlast)
    );

    assign o_m_tuser = out_kind;

endmodule

>>> rtl/core/tafg_checker.sv
// Port-level checks of the tile fetch generator, bound to the top level.
module tafg_checker
    import tafg_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tuser,
    input logic                  o_m_tlast
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result item changed");

    // Reset empties the output register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result item valid after reset");

    // A full tileset tile is a run of its own and has no sheet.
    a_tile_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_TILE |-> o_m_tlast && o_m_tdata[2:0] == '0)
        else $error("tileset rectangle not alone or with a sheet");

    // Quarters of one autotile share the sheet.
    a_quarter_sheet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser == KIND_QUARTER && !o_m_tlast
        |=> o_m_tvalid && o_m_tuser == KIND_QUARTER
            && o_m_tdata[2:0] == $past(o_m_tdata[2:0]))
        else $error("autotile quarters broken apart");

endmodule

bind tilemap_autotile_fetch_generator tafg_checker u_tafg_checker (.*);
